>>> rtl/core/mrq_pkg.sv
// Shared definitions for the multilevel ready queue scheduler.
// Request and status codes, field widths and parameter defaults.
// No dependencies.
package mrq_pkg;

    localparam int PROC_COUNT_DEF  = 16;
    localparam int LEVEL_COUNT_DEF = 8;

    localparam int PROC_ID_W  = 4;
    localparam int PRIO_W     = 3;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [REQ_W-1:0] REQ_MAKE_READY = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CHOOSE     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESCHED    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 2'd2;

    localparam logic [APB_AW-1:0] REG_IDLE_PROC_ADDR = 3'd0;

endpackage

>>> rtl/core/mrq_ram.sv
// Simple dual-port synchronous RAM with one write and one registered read port.
// Holds the per-process link and level tables. No dependencies.
module mrq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 4,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/mrq_lvl_pick.sv
// Priority encoder that finds the lowest non-empty priority level.
// No dependencies.
module mrq_lvl_pick #(
    parameter int LEVEL_COUNT = 8,
    parameter int LW          = 3
) (
    input  logic [LEVEL_COUNT-1:0] nonempty,
    output logic                   found,
    output logic [LW-1:0]          lvl
);

    always_comb
    begin
        found = |nonempty;
        lvl   = '0;
        // Scan downward so that the lowest set bit wins.
        for (int i = LEVEL_COUNT - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                lvl = LW'(i);
            end
        end
    end

endmodule

>>> rtl/core/multilevel_ready_queue_scheduler.sv
// Top level of the multilevel ready queue scheduler: control sequencer, list
// head/tail registers and APB register. Uses mrq_pkg, mrq_ram, mrq_lvl_pick.
//
//  channel   direction  handshake               contents
//  s_axis    in         tvalid/tready           request: type, process, level
//  m_axis    out        tvalid/tready           chosen process, idle flag, status
//  apb       in         psel/penable/pready     idle_proc register at 0x0
//
// Make ready, a refused reschedule and the unused type go from decode straight to
// the result state; choose passes a head-update state when entries remain behind
// the chosen one. Reschedule reads the level RAM, then unlinks a lone or head
// process at once or walks the list, one link RAM read per cycle, bypasses it and
// re-appends it to level 0. A new request is taken while a result still waits on
// m_axis; the sequencer stalls in its last state until the output register is free.
// Reset clears all levels and queued marks; no clearing pass is needed.
module multilevel_ready_queue_scheduler #(
    parameter int PROC_COUNT  = mrq_pkg::PROC_COUNT_DEF,
    parameter int LEVEL_COUNT = mrq_pkg::LEVEL_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [3:0] proc_id, [6:4] priority_req, [7] zero
    input  logic [7:0]                    s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] chosen_proc, [5:4] status, [7:6] zero
    output logic [7:0]                    m_axis_tdata,
    // [0] chose_idle
    output logic [0:0]                    m_axis_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrq_pkg::APB_AW-1:0]    paddr,
    input  logic [mrq_pkg::APB_DW-1:0]    pwdata,
    output logic [mrq_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    import mrq_pkg::*;

    localparam int PW = $clog2(PROC_COUNT);
    localparam int LW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_CHOOSE    = 4'd2;
    localparam logic [3:0] S_RS_LVL    = 4'd3;
    localparam logic [3:0] S_RS_HEAD   = 4'd4;
    localparam logic [3:0] S_WALK      = 4'd5;
    localparam logic [3:0] S_RS_BYPASS = 4'd6;
    localparam logic [3:0] S_APPEND0   = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    // Control state
    logic [3:0]             state_reg, state_next;
    logic [LEVEL_COUNT-1:0] nonempty_reg, nonempty_next;
    logic [PROC_COUNT-1:0]  queued_reg, queued_next;
    logic                   out_valid_reg, out_valid_next;
    logic [PROC_ID_W-1:0]   idle_proc_reg;

    // Payload state
    logic [PW-1:0]          head_reg [LEVEL_COUNT];
    logic [PW-1:0]          head_next [LEVEL_COUNT];
    logic [PW-1:0]          tail_reg [LEVEL_COUNT];
    logic [PW-1:0]          tail_next [LEVEL_COUNT];
    logic [REQ_W-1:0]       req_reg, req_next;
    logic [PROC_ID_W-1:0]   pid_reg, pid_next;
    logic [PRIO_W-1:0]      prio_reg, prio_next;
    logic [LW-1:0]          lvl_reg, lvl_next;
    logic [PW-1:0]          prev_reg, prev_next;
    logic [PROC_ID_W-1:0]   res_chosen_reg, res_chosen_next;
    logic                   res_idle_reg, res_idle_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [PROC_ID_W-1:0]   out_chosen_reg, out_chosen_next;
    logic                   out_idle_reg, out_idle_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;

    // RAM ports
    logic                   link_we;
    logic [PW-1:0]          link_waddr, link_wdata, link_raddr, link_rdata;
    logic                   lvlm_we;
    logic [PW-1:0]          lvlm_waddr, lvlm_raddr;
    logic [LW-1:0]          lvlm_wdata, lvlm_rdata;

    logic                   pick_found;
    logic [LW-1:0]          pick_lvl;

    logic [31:0]            pid32, prio32, sat32, chosen32;
    logic [PW-1:0]          pidx, hsel, cur;
    logic                   pid_ok;
    logic [LW-1:0]          mk_lvl;
    logic                   cfg_write;

    mrq_ram #(.DEPTH(PROC_COUNT), .WIDTH(PW), .AW(PW)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    mrq_ram #(.DEPTH(PROC_COUNT), .WIDTH(LW), .AW(PW)) u_level_ram (
        .clk   (clk),
        .we    (lvlm_we),
        .waddr (lvlm_waddr),
        .wdata (lvlm_wdata),
        .raddr (lvlm_raddr),
        .rdata (lvlm_rdata)
    );

    mrq_lvl_pick #(.LEVEL_COUNT(LEVEL_COUNT), .LW(LW)) u_pick (
        .nonempty (nonempty_reg),
        .found    (pick_found),
        .lvl      (pick_lvl)
    );

    assign pid32  = 32'(pid_reg);
    assign pid_ok = pid32 < 32'(PROC_COUNT);
    assign pidx   = pid32[PW-1:0];
    assign prio32 = 32'(prio_reg);
    assign sat32  = (prio32 >= 32'(LEVEL_COUNT)) ? 32'(LEVEL_COUNT - 1) : prio32;
    assign mk_lvl = sat32[LW-1:0];
    assign hsel   = head_reg[pick_lvl];
    assign chosen32 = 32'(hsel);
    assign cur    = head_reg[lvlm_rdata];

    always_comb
    begin
        state_next      = state_reg;
        nonempty_next   = nonempty_reg;
        queued_next     = queued_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        req_next        = req_reg;
        pid_next        = pid_reg;
        prio_next       = prio_reg;
        lvl_next        = lvl_reg;
        prev_next       = prev_reg;
        res_chosen_next = res_chosen_reg;
        res_idle_next   = res_idle_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_chosen_next = out_chosen_reg;
        out_idle_next   = out_idle_reg;
        out_status_next = out_status_reg;
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_raddr = '0;
        lvlm_we    = 1'b0;
        lvlm_waddr = '0;
        lvlm_wdata = '0;
        lvlm_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next   = s_axis_tuser;
                    pid_next   = s_axis_tdata[3:0];
                    prio_next  = s_axis_tdata[6:4];
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_chosen_next = '0;
                res_idle_next   = 1'b0;
                res_status_next = ST_OK;
                state_next      = S_DONE;
                case (req_reg)
                    REQ_MAKE_READY:
                    begin
                        if (!pid_ok || pid_reg == idle_proc_reg || queued_reg[pidx])
                        begin
                            res_status_next = ST_IGNORED;
                        end
                        else
                        begin
                            if (nonempty_reg[mk_lvl])
                            begin
                                link_we    = 1'b1;
                                link_waddr = tail_reg[mk_lvl];
                                link_wdata = pidx;
                            end
                            else
                            begin
                                head_next[mk_lvl] = pidx;
                            end
                            tail_next[mk_lvl]     = pidx;
                            nonempty_next[mk_lvl] = 1'b1;
                            lvlm_we               = 1'b1;
                            lvlm_waddr            = pidx;
                            lvlm_wdata            = mk_lvl;
                            queued_next[pidx]     = 1'b1;
                        end
                    end

                    REQ_CHOOSE:
                    begin
                        if (pick_found)
                        begin
                            res_chosen_next   = chosen32[PROC_ID_W-1:0];
                            queued_next[hsel] = 1'b0;
                            lvl_next          = pick_lvl;
                            if (tail_reg[pick_lvl] == hsel)
                            begin
                                nonempty_next[pick_lvl] = 1'b0;
                            end
                            else
                            begin
                                link_raddr = hsel;
                                state_next = S_CHOOSE;
                            end
                        end
                        else
                        begin
                            res_chosen_next = idle_proc_reg;
                            res_idle_next   = 1'b1;
                        end
                    end

                    REQ_RESCHED:
                    begin
                        if (!pid_ok || !queued_reg[pidx])
                        begin
                            res_status_next = ST_NOT_QUEUED;
                        end
                        else
                        begin
                            lvlm_raddr = pidx;
                            state_next = S_RS_LVL;
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_CHOOSE:
            begin
                head_next[lvl_reg] = link_rdata;
                state_next         = S_DONE;
            end

            S_RS_LVL:
            begin
                lvl_next = lvlm_rdata;
                if (!nonempty_reg[lvlm_rdata])
                begin
                    state_next = S_APPEND0;
                end
                else if (cur == pidx)
                begin
                    // The process is the head of its list.
                    if (tail_reg[lvlm_rdata] == pidx)
                    begin
                        nonempty_next[lvlm_rdata] = 1'b0;
                        state_next                = S_APPEND0;
                    end
                    else
                    begin
                        link_raddr = pidx;
                        state_next = S_RS_HEAD;
                    end
                end
                else
                begin
                    prev_next  = cur;
                    link_raddr = cur;
                    state_next = S_WALK;
                end
            end

            S_RS_HEAD:
            begin
                head_next[lvl_reg] = link_rdata;
                state_next         = S_APPEND0;
            end

            S_WALK:
            begin
                // link_rdata is the successor of prev_reg.
                if (prev_reg == tail_reg[lvl_reg])
                begin
                    state_next = S_APPEND0;
                end
                else if (link_rdata == pidx)
                begin
                    link_raddr = pidx;
                    state_next = S_RS_BYPASS;
                end
                else
                begin
                    prev_next  = link_rdata;
                    link_raddr = link_rdata;
                end
            end

            S_RS_BYPASS:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = link_rdata;
                if (tail_reg[lvl_reg] == pidx)
                begin
                    tail_next[lvl_reg] = prev_reg;
                end
                state_next = S_APPEND0;
            end

            S_APPEND0:
            begin
                if (nonempty_reg[0])
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_reg[0];
                    link_wdata = pidx;
                end
                else
                begin
                    head_next[0] = pidx;
                end
                tail_next[0]     = pidx;
                nonempty_next[0] = 1'b1;
                lvlm_we          = 1'b1;
                lvlm_waddr       = pidx;
                lvlm_wdata       = '0;
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_chosen_next = res_chosen_reg;
                    out_idle_next   = res_idle_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_IDLE_PROC_ADDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nonempty_reg  <= '0;
            queued_reg    <= '0;
            out_valid_reg <= 1'b0;
            idle_proc_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            nonempty_reg  <= nonempty_next;
            queued_reg    <= queued_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                idle_proc_reg <= pwdata[PROC_ID_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg       <= head_next;
        tail_reg       <= tail_next;
        req_reg        <= req_next;
        pid_reg        <= pid_next;
        prio_reg       <= prio_next;
        lvl_reg        <= lvl_next;
        prev_reg       <= prev_next;
        res_chosen_reg <= res_chosen_next;
        res_idle_reg   <= res_idle_next;
        res_status_reg <= res_status_next;
        out_chosen_reg <= out_chosen_next;
        out_idle_reg   <= out_idle_next;
        out_status_reg <= out_status_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_status_reg, out_chosen_reg};
    assign m_axis_tuser  = out_idle_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr == REG_IDLE_PROC_ADDR)
                           ? {{(APB_DW - PROC_ID_W){1'b0}}, idle_proc_reg} : '0;

    // An accepted transaction always moves the sequencer on to decode.
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_DECODE))
        else $error("accepted transaction did not enter decode");

    // A non-empty level implies at least one process is marked queued.
    a_nonempty_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (nonempty_reg != '0) |-> (queued_reg != '0))
        else $error("non-empty level with no queued process");

    // The list walk only leaves toward the bypass or the re-append.
    a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |=> (state_reg == S_WALK || state_reg == S_RS_BYPASS ||
                                   state_reg == S_APPEND0))
        else $error("unexpected exit from list walk");

    // An idle pick never carries an error status.
    a_idle_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[5:4] == ST_OK))
        else $error("idle result with non-zero status");

endmodule
